@@ rtl/spq_pkg.sv @@
// spq_pkg: shared types and codes for the stable minimum priority queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
`default_nettype none

package spq_pkg;

  localparam int VALUE_W   = 32;
  localparam int RANK_IN_W = 8;

  // Codes of the action field.
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Controller states: the output register is empty or holds a result.
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_HOLD = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;    // capture a result into the output register
    logic    do_enq;  // insert the incoming entry
    logic    do_deq;  // remove the front entry
    status_t res;     // status code of the result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/spq_ifs.sv @@
// spq_ifs: valid/ready channel interfaces for queue operations and results.
// Depends on spq_pkg for field widths and the status type.
`default_nettype none

interface spq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [spq_pkg::VALUE_W-1:0] item_value;
  logic [spq_pkg::RANK_IN_W-1:0]      item_rank;

  modport source (output valid, action, item_value, item_rank, input ready);
  modport sink   (input valid, action, item_value, item_rank, output ready);
endinterface

interface spq_out_if #(parameter int CNT_W = 5);
  logic                               valid;
  logic                               ready;
  spq_pkg::status_t                   status;
  logic signed [spq_pkg::VALUE_W-1:0] out_value;
  logic [spq_pkg::RANK_IN_W-1:0]      out_rank;
  logic [CNT_W-1:0]                   fill_count;

  modport source (output valid, status, out_value, out_rank, fill_count, input ready);
  modport sink   (input valid, status, out_value, out_rank, fill_count, output ready);
endinterface

`default_nettype wire

@@ rtl/stable_min_priority_queue.sv @@
// stable_min_priority_queue: top level of a sorted shift-register priority queue.
// Joins spq_ctrl and spq_dp; depends on spq_pkg and the interfaces in spq_ifs.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        action, item_value, item_rank
//   out_ch    source     valid/ready        status, out_value, out_rank, fill_count
//
// Every operation completes in the cycle it is accepted; its result is registered
// and shown on out_ch in the next cycle. One transaction per cycle is sustained
// while out_ch is ready, as the row of slot comparators places the entry in one step.
// While out_ch is stalled, one result waits in the output register and in_ch is held off.
// Synchronous active-low reset empties the queue; slot contents are not cleared.
// out_ch must be built with CNT_W equal to $clog2(CAPACITY+1).
`default_nettype none

module stable_min_priority_queue #(
  parameter int CAPACITY  = 16,
  parameter int RANK_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  dp_cmd_t    cmd;
  dp_status_t st;
  logic [CNT_W-1:0] fill;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  spq_dp #(
    .CAPACITY  (CAPACITY),
    .RANK_BITS (RANK_BITS),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_value   (in_ch.item_value),
    .in_rank    (in_ch.item_rank),
    .res_status (out_ch.status),
    .res_value  (out_ch.out_value),
    .res_rank   (out_ch.out_rank),
    .res_fill   (fill)
  );

  assign out_ch.fill_count = fill;

endmodule

`default_nettype wire

@@ rtl/spq_ctrl.sv @@
// spq_ctrl: handshake controller of the priority queue.
// Tracks the output register and issues commands to spq_dp; depends on spq_pkg.
`default_nettype none

module spq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  spq_pkg::dp_status_t st,
  output spq_pkg::dp_cmd_t    cmd
);
  import spq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (accept) state_nxt = CS_HOLD;
      end
      CS_HOLD: begin
        if (accept) state_nxt = CS_HOLD;
        else if (out_ready) state_nxt = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_ready = 1'b1;
      end
      CS_HOLD: begin
        out_valid = 1'b1;
        // The waiting result leaves in this cycle, so a new one may enter.
        in_ready  = out_ready;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.load   = accept;
    cmd.do_enq = accept && (in_action == ACT_ENQ) && !st.full;
    cmd.do_deq = accept && (in_action == ACT_DEQ) && !st.empty;
    if (in_action == ACT_ENQ) cmd.res = st.full ? ST_FULL : ST_ENQ;
    else                      cmd.res = st.empty ? ST_EMPTY : ST_DEQ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= CS_IDLE;
    else        state_r <= state_nxt;
  end

  a_no_enq_and_deq: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_enq && cmd.do_deq))
    else $error("enqueue and dequeue commanded together");

  a_op_needs_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_enq || cmd.do_deq) |-> cmd.load)
    else $error("queue update without a captured result");

  a_result_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid)
    else $error("captured result not presented");

endmodule

`default_nettype wire

@@ rtl/spq_dp.sv @@
// spq_dp: datapath of the priority queue: a sorted row of slot registers,
// the entry count and the output result register. Depends on spq_pkg.
`default_nettype none

module spq_dp #(
  parameter int CAPACITY  = 16,
  parameter int RANK_BITS = 8,
  parameter int CNT_W     = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spq_pkg::dp_cmd_t                    cmd,
  output spq_pkg::dp_status_t                 st,
  input  logic signed [spq_pkg::VALUE_W-1:0]  in_value,
  input  logic [spq_pkg::RANK_IN_W-1:0]       in_rank,
  output spq_pkg::status_t                    res_status,
  output logic signed [spq_pkg::VALUE_W-1:0]  res_value,
  output logic [spq_pkg::RANK_IN_W-1:0]       res_rank,
  output logic [CNT_W-1:0]                    res_fill
);
  import spq_pkg::*;

  logic signed [VALUE_W-1:0] slot_value_r   [CAPACITY];
  logic [RANK_BITS-1:0]      slot_rank_r    [CAPACITY];
  logic signed [VALUE_W-1:0] slot_value_nxt [CAPACITY];
  logic [RANK_BITS-1:0]      slot_rank_nxt  [CAPACITY];
  logic [CAPACITY-1:0]       goes_after;
  logic [CNT_W-1:0]          count_r, count_nxt;

  logic [RANK_BITS+RANK_IN_W-1:0] rank_in_ext;
  logic [RANK_BITS+RANK_IN_W-1:0] rank_out_ext;
  logic [RANK_BITS-1:0]           new_rank;

  status_t                   status_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [RANK_IN_W-1:0]      rank_r;
  logic [CNT_W-1:0]          fill_r;

  // Only the low RANK_BITS bits of an incoming rank are kept.
  assign rank_in_ext  = {{RANK_BITS{1'b0}}, in_rank};
  assign new_rank     = rank_in_ext[RANK_BITS-1:0];
  assign rank_out_ext = {{RANK_IN_W{1'b0}}, slot_rank_r[0]};

  assign st.empty = (count_r == '0);
  assign st.full  = (count_r == CNT_W'(CAPACITY));

  // Each held slot compares its rank with the new one; the new entry goes
  // behind every held entry of equal or lower rank.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      goes_after[i] = (CNT_W'(i) < count_r) && (slot_rank_r[i] <= new_rank);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_value_nxt[i] = slot_value_r[i];
      slot_rank_nxt[i]  = slot_rank_r[i];
    end
    count_nxt = count_r;
    if (cmd.do_enq) begin
      if (!goes_after[0]) begin
        slot_value_nxt[0] = in_value;
        slot_rank_nxt[0]  = new_rank;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (!goes_after[i]) begin
          if (goes_after[i-1]) begin
            slot_value_nxt[i] = in_value;
            slot_rank_nxt[i]  = new_rank;
          end else begin
            slot_value_nxt[i] = slot_value_r[i-1];
            slot_rank_nxt[i]  = slot_rank_r[i-1];
          end
        end
      end
      count_nxt = count_r + 1'b1;
    end else if (cmd.do_deq) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        slot_value_nxt[i] = slot_value_r[i+1];
        slot_rank_nxt[i]  = slot_rank_r[i+1];
      end
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_value_r[i] <= slot_value_nxt[i];
      slot_rank_r[i]  <= slot_rank_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= cmd.res;
      value_r  <= cmd.do_deq ? slot_value_r[0] : '0;
      rank_r   <= cmd.do_deq ? rank_out_ext[RANK_IN_W-1:0] : '0;
      fill_r   <= count_nxt;
    end
  end

  assign res_status = status_r;
  assign res_value  = value_r;
  assign res_rank   = rank_r;
  assign res_fill   = fill_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_enq |=> count_r == $past(count_r) + 1'b1)
    else $error("enqueue did not grow the count");

  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_deq |=> count_r == $past(count_r) - 1'b1)
    else $error("dequeue did not shrink the count");

  a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> (slot_rank_r[0] <= slot_rank_r[1]))
    else $error("front entries out of rank order");

endmodule

`default_nettype wire

@@ sim/stable_min_priority_queue_test.sv @@
// Self-checking testbench for the stable minimum priority queue.
// Uses spq_pkg, the channel interfaces in spq_ifs and the RTL top level.
// A scoreboard keeps its own sorted copy of the queue and checks every result.

class spq_scoreboard #(int DEPTH = 16, int RBITS = 8, int CW = 5);

  typedef struct {
    spq_pkg::status_t    status;
    logic signed [31:0]  value;
    logic [7:0]          rank;
    logic [CW-1:0]       fill;
  } result_t;

  logic signed [31:0] held_value[DEPTH];
  logic [7:0]         held_rank[DEPTH];
  int unsigned        held;
  result_t            expected_results[$];
  int unsigned        mismatches;
  int unsigned        results_seen;
  int unsigned        status_seen[4];
  int unsigned        peak_fill;

  function new();
    held = 0;
    mismatches = 0;
    results_seen = 0;
    peak_fill = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function int unsigned outstanding();
    return expected_results.size();
  endfunction

  // Work out the result of one accepted transaction and update the shadow queue.
  function void note_op(logic act, logic signed [31:0] val, logic [7:0] rank_in);
    result_t     r;
    logic [7:0]  kept;
    int unsigned pos;
    kept = rank_in & 8'((64'd1 << RBITS) - 64'd1);
    r.value = '0;
    r.rank  = '0;
    if (act == spq_pkg::ACT_ENQ) begin
      if (held >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // Equal ranks stay in arrival order: insert behind every rank <= kept.
        pos = 0;
        while (pos < held && held_rank[pos] <= kept) pos++;
        for (int unsigned i = held; i > pos; i--) begin
          held_value[i] = held_value[i-1];
          held_rank[i]  = held_rank[i-1];
        end
        held_value[pos] = val;
        held_rank[pos]  = kept;
        held++;
        r.status = spq_pkg::ST_ENQ;
      end
    end else begin
      if (held == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.value = held_value[0];
        r.rank  = held_rank[0];
        for (int unsigned i = 1; i < held; i++) begin
          held_value[i-1] = held_value[i];
          held_rank[i-1]  = held_rank[i];
        end
        held--;
        r.status = spq_pkg::ST_DEQ;
      end
    end
    r.fill = CW'(held);
    if (held > peak_fill) peak_fill = held;
    expected_results.push_back(r);
  endfunction

  function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatches++;
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, exp_v, act_v);
  endfunction

  function void check_result(spq_pkg::status_t status, logic signed [31:0] value,
                             logic [7:0] rank, logic [CW-1:0] fill);
    result_t e;
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected: status %0h value %0h rank %0h fill %0d",
               $time, status, value, rank, fill);
      return;
    end
    e = expected_results.pop_front();
    status_seen[e.status]++;
    if (status !== e.status) flag("status", 32'(e.status), 32'(status));
    if (value !== e.value)   flag("out_value", e.value, value);
    if (rank !== e.rank)     flag("out_rank", 32'(e.rank), 32'(rank));
    if (fill !== e.fill)     flag("fill_count", 32'(e.fill), 32'(fill));
  endfunction

endclass

module stable_min_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANK_BITS    = 8;
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int RANDOM_OPS   = 1850;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  int   cycles = 0;

  spq_scoreboard #(CAPACITY, RANK_BITS, CNT_W) board;

  spq_in_if                   in_ch();
  spq_out_if #(.CNT_W(CNT_W)) out_ch();

  stable_min_priority_queue #(
    .CAPACITY (CAPACITY),
    .RANK_BITS(RANK_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("stable_min_priority_queue_test failed");
      $finish;
    end
  end

  // Result side: sample at the edge, then pick the ready level for the next cycle.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_result(out_ch.status, out_ch.out_value, out_ch.out_rank,
                           out_ch.fill_count);
      out_ch.ready <= rst_n && ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Present one operation and hold it until the transaction completes.
  // Valid is only lowered while idling, so back-to-back items keep it high.
  task automatic send_op(input logic act, input logic signed [31:0] val,
                         input logic [7:0] rank);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.action     <= 1'($urandom);
      in_ch.item_value <= $urandom;
      in_ch.item_rank  <= 8'($urandom);
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.item_value <= val;
    in_ch.item_rank  <= rank;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_op(act, val, rank);
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  function automatic logic [7:0] pick_rank();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return 8'($urandom_range(3));      // dense ties
    if (sel < 58) return 8'd0;
    if (sel < 66) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4) return 32'sh7fff_ffff;
    if (sel < 8) return 32'sh8000_0000;
    if (sel < 10) return '0;
    return $urandom;
  endfunction

  initial begin
    int unsigned mode;
    int unsigned phase_left;
    int unsigned enq_pct;
    logic        act;

    board        = new();
    in_idle_pct  = 34;
    out_idle_pct = 34;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_ENQ;
    in_ch.item_value <= '0;
    in_ch.item_rank  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty dequeue, field extremes, stable ties, overflow, four ordered dequeues.
    send_op(ACT_DEQ, 32'sh1234_5678, 8'd77);
    send_op(ACT_ENQ, 32'sh7fff_ffff, 8'd255);
    send_op(ACT_ENQ, 32'sh8000_0000, 8'd0);
    send_op(ACT_ENQ, 32'sh0000_0000, 8'd255);
    send_op(ACT_ENQ, -32'sd1,        8'd0);
    for (int i = 0; i < CAPACITY - 4; i++)
      send_op(ACT_ENQ, 32'(i + 1), 8'd100 + 8'(i % 3));
    send_op(ACT_ENQ, 32'sh5555_aaaa, 8'd0);
    repeat (4) send_op(ACT_DEQ, $urandom, 8'($urandom));

    // Random phases swing the occupancy between empty and full.
    phase_left = 0;
    enq_pct    = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (phase_left == 0) begin
        mode       = $urandom_range(2);
        phase_left = $urandom_range(20, 120);
        enq_pct    = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      end
      phase_left--;
      if (n == 600) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else if (n == 1000) begin
        in_idle_pct  = 34;
        out_idle_pct = 34;
      end
      if (n == 1300) drain_wait();
      act = ($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
      send_op(act, pick_value(), pick_rank());
    end

    in_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d transactions in %0d cycles, peak occupancy %0d of %0d.",
             board.results_seen, cycles, board.peak_fill, CAPACITY);
    $display("Inserted %0d, removed %0d, empty dequeues %0d, dropped on full %0d.",
             board.status_seen[ST_ENQ], board.status_seen[ST_DEQ],
             board.status_seen[ST_EMPTY], board.status_seen[ST_FULL]);
    if (board.mismatches == 0) begin
      $display("stable_min_priority_queue_test passed");
    end else begin
      $display("stable_min_priority_queue_test failed");
    end
    $finish;
  end

endmodule
